// ----- sv/pva_pkg.sv -----
`default_nettype none
package pva_pkg;
   localparam int TABLE_LEN = 24;
   localparam int MAG_W = 16;
   localparam int ANG_W = 17;
   localparam int SMAG_W = 17;
   localparam int SANG_W = 15;
   localparam logic signed [31:0] KINV = 32'sd652032874;
   localparam logic signed [17:0] TURN_UNITS = 18'sd23040;
   localparam logic signed [17:0] HALF_TURN = 18'sd11520;
   localparam logic signed [17:0] QUARTER_TURN = 18'sd5760;
   localparam logic [16:0] MAG_LIMIT = 17'd65536;
   // rotation datapath width: |mag*kinv| < 2^45, gain 1.65
   localparam int RX_W = 50;
   // vectoring datapath width at 2^-12 lsb
   localparam int VX_W = 34;
   localparam int Z_W = 40;

   function automatic logic signed [39:0] atan_step(input int i);
      logic [31:0] t;
      case (i)
         0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
         3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
         6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
         9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
         12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
         15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
         18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
         21: t = 32'd326;       22: t = 32'd163;       default: t = 32'd81;
      endcase
      atan_step = 40'(signed'({8'd0, t}) * 40'sd90);
   endfunction
endpackage
`default_nettype wire

// ----- sv/polar_vector_adder_unit.sv -----
`default_nettype none
// polar vector adder: adds two vectors given as signed magnitude (1/1024 m/s)
// and angle (1/64 degree), returns length and direction of their sum
// input: req_* fields are taken when start is high; busy is always low, so a
// word can be taken on every clock
// output: rsp_valid strobes for one cycle with rsp_sum_magnitude and
// rsp_sum_angle; words leave in the order they came in
// pipeline: the rotation cordic (one stage per iteration after reduction and
// gain multiply), the add stage and the vectoring cordic followed by the gain
// multiply and rounding
// throughput: one word per cycle
// reset clears the valid pipeline only; words in flight are dropped
// the receiver cannot stall, so nothing is ever held back
module polar_vector_adder_unit #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire logic signed [15:0] req_first_magnitude,
   input  wire logic signed [16:0] req_first_angle,
   input  wire logic signed [15:0] req_second_magnitude,
   input  wire logic signed [16:0] req_second_angle,
   output logic              rsp_valid,
   output logic [16:0]       rsp_sum_magnitude,
   output logic signed [14:0] rsp_sum_angle
);
   localparam int N = (CORDIC_STAGES < pva_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                             : pva_pkg::TABLE_LEN;
   localparam int LAT = 2 * N + 5;
   localparam int VW = pva_pkg::VX_W;
   localparam int ZW = pva_pkg::Z_W;

   assign busy = 1'b0;

   logic [LAT-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[LAT-2:0], start};
   end
   assign rsp_valid = vld_ff[LAT-1];

   logic signed [VW-1:0] x1, y1, x2, y2;
   pva_rotate #(.STAGES(CORDIC_STAGES)) u_rot1 (
      .clock(clock), .mag(req_first_magnitude), .ang(req_first_angle),
      .x_out(x1), .y_out(y1));
   pva_rotate #(.STAGES(CORDIC_STAGES)) u_rot2 (
      .clock(clock), .mag(req_second_magnitude), .ang(req_second_angle),
      .x_out(x2), .y_out(y2));

   // add, zero detect and half-plane fold
   logic signed [VW-1:0] sx, sy;
   assign sx = x1 + x2;
   assign sy = y1 + y2;

   logic signed [VW-1:0] vx_ff [0:N];
   logic signed [VW-1:0] vy_ff [0:N];
   logic signed [ZW-1:0] vz_ff [0:N];
   logic [N:0] flip_ff, zero_ff;

   always_ff @(posedge clock) begin
      zero_ff[0] <= (sx == 0) && (sy == 0);
      flip_ff[0] <= sx < 0;
      vx_ff[0] <= (sx < 0) ? -sx : sx;
      vy_ff[0] <= (sx < 0) ? -sy : sy;
      vz_ff[0] <= '0;
   end

   for (genvar i = 0; i < N; i++) begin : g_vec
      always_ff @(posedge clock) begin
         flip_ff[i+1] <= flip_ff[i];
         zero_ff[i+1] <= zero_ff[i];
         if (vy_ff[i] < 0) begin
            vx_ff[i+1] <= vx_ff[i] - (vy_ff[i] >>> i);
            vy_ff[i+1] <= vy_ff[i] + (vx_ff[i] >>> i);
            vz_ff[i+1] <= vz_ff[i] - pva_pkg::atan_step(i);
         end else begin
            vx_ff[i+1] <= vx_ff[i] + (vy_ff[i] >>> i);
            vy_ff[i+1] <= vy_ff[i] - (vx_ff[i] >>> i);
            vz_ff[i+1] <= vz_ff[i] + pva_pkg::atan_step(i);
         end
      end
   end

   // gain multiply and angle rounding
   logic signed [65:0] prod_ff;
   logic signed [15:0] ang_ff;
   logic flip2_ff, zero2_ff;
   logic signed [ZW-1:0] zr;
   assign zr = (vz_ff[N] + ZW'(1 <<< 23)) >>> 24;
   always_ff @(posedge clock) begin
      prod_ff <= 66'(vx_ff[N]) * 66'(pva_pkg::KINV);
      ang_ff <= zr[15:0];
      flip2_ff <= flip_ff[N];
      zero2_ff <= zero_ff[N];
   end

   logic signed [65:0] mag_w;
   logic signed [15:0] ang_w;
   logic [16:0] mag_in;
   always_comb begin
      mag_w = (prod_ff + (66'sd1 <<< 41)) >>> 42;
      if (mag_w < 0) mag_in = '0;
      else if (mag_w > 66'(pva_pkg::MAG_LIMIT)) mag_in = pva_pkg::MAG_LIMIT;
      else mag_in = mag_w[16:0];
      ang_w = ang_ff;
      if (flip2_ff) begin
         if (ang_w > 0) ang_w = ang_w - 16'(pva_pkg::HALF_TURN);
         else ang_w = ang_w + 16'(pva_pkg::HALF_TURN);
      end
      if (zero2_ff) begin
         mag_in = '0;
         ang_w = '0;
      end
   end

   logic [16:0] mag_ff;
   logic signed [14:0] oang_ff;
   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      oang_ff <= ang_w[14:0];
   end
   assign rsp_sum_magnitude = mag_ff;
   assign rsp_sum_angle = oang_ff;
endmodule
`default_nettype wire

// ----- sv/pva_rotate.sv -----
`default_nettype none
// polar to cartesian, one cordic iteration per stage
module pva_rotate #(
   parameter int STAGES = 16
) (
   input  wire logic                                 clock,
   input  wire logic signed [pva_pkg::MAG_W-1:0]     mag,
   input  wire logic signed [pva_pkg::ANG_W-1:0]     ang,
   output logic signed [pva_pkg::VX_W-1:0]           x_out,
   output logic signed [pva_pkg::VX_W-1:0]           y_out
);
   localparam int RW = pva_pkg::RX_W;
   localparam int ZW = pva_pkg::Z_W;
   localparam int N = (STAGES < pva_pkg::TABLE_LEN) ? STAGES : pva_pkg::TABLE_LEN;
   localparam int MAG_W_L = pva_pkg::MAG_W;
   localparam logic signed [17:0] TURN2 = 18'(2 * pva_pkg::TURN_UNITS);
   localparam logic signed [17:0] TURN3 = 18'(3 * pva_pkg::TURN_UNITS);
   localparam logic signed [17:0] WRAP1 = 18'(pva_pkg::HALF_TURN + pva_pkg::TURN_UNITS);
   localparam logic signed [17:0] WRAP2 = 18'(pva_pkg::HALF_TURN + TURN2);

   logic signed [17:0] r_ff;
   logic signed [MAG_W_L-1:0] m_ff;
   logic neg_ff;
   logic signed [17:0] r_in, a_w;
   logic neg_in;

   // stage 0: angle reduction
   always_comb begin
      a_w = {ang[pva_pkg::ANG_W-1], ang};
      // bring the angle into one turn by compare and subtract
      if (a_w >= WRAP2) r_in = a_w - TURN3;
      else if (a_w >= WRAP1) r_in = a_w - TURN2;
      else if (a_w >= pva_pkg::HALF_TURN) r_in = a_w - pva_pkg::TURN_UNITS;
      else if (a_w < -WRAP2) r_in = a_w + TURN3;
      else if (a_w < -WRAP1) r_in = a_w + TURN2;
      else if (a_w < -pva_pkg::HALF_TURN) r_in = a_w + pva_pkg::TURN_UNITS;
      else r_in = a_w;
      neg_in = 1'b0;
      if (r_in > pva_pkg::QUARTER_TURN) begin
         r_in = r_in - pva_pkg::HALF_TURN;
         neg_in = 1'b1;
      end else if (r_in < -pva_pkg::QUARTER_TURN) begin
         r_in = r_in + pva_pkg::HALF_TURN;
         neg_in = 1'b1;
      end
   end

   logic signed [RW-1:0] x_ff [0:N];
   logic signed [RW-1:0] y_ff [0:N];
   logic signed [ZW-1:0] z_ff [0:N];

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      m_ff <= mag;
      neg_ff <= neg_in;
   end

   // stage 1: gain multiply
   logic signed [RW-1:0] xm;
   always_comb begin
      xm = RW'(m_ff) * RW'(pva_pkg::KINV);
      if (neg_ff) xm = -xm;
   end
   always_ff @(posedge clock) begin
      x_ff[0] <= xm;
      y_ff[0] <= '0;
      z_ff[0] <= ZW'(r_ff) <<< 24;
   end

   for (genvar i = 0; i < N; i++) begin : g_it
      always_ff @(posedge clock) begin
         if (z_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - pva_pkg::atan_step(i);
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + pva_pkg::atan_step(i);
         end
      end
   end

   logic signed [RW-1:0] xr, yr;
   assign xr = (x_ff[N] + RW'(1 <<< 17)) >>> 18;
   assign yr = (y_ff[N] + RW'(1 <<< 17)) >>> 18;
   assign x_out = xr[pva_pkg::VX_W-1:0];
   assign y_out = yr[pva_pkg::VX_W-1:0];
endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

   localparam int STAGES = 16;
   localparam int LATENCY = 2 * STAGES + 5;
   localparam int WATCHDOG_LIMIT = LATENCY + 200;

   typedef struct packed {
      logic [16:0] magnitude;
      logic signed [14:0] angle;
   } polar_sum_type;

   localparam longint ATAN_TURNS [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

   int error_count = 0;

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic longint floor_shift(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic void polar_to_xy(input longint mag, input longint ang,
                                       output longint ox, output longint oy);
      longint r, x, y, z, dx, dy;
      r = ang % longint'(pva_pkg::TURN_UNITS);
      x = mag * longint'(pva_pkg::KINV);
      y = 0;
      if (r < 0) r += pva_pkg::TURN_UNITS;
      if (r >= pva_pkg::HALF_TURN) r -= pva_pkg::TURN_UNITS;
      if (r > pva_pkg::QUARTER_TURN) begin
         r -= pva_pkg::HALF_TURN;
         x = -x;
      end else if (r < -pva_pkg::QUARTER_TURN) begin
         r += pva_pkg::HALF_TURN;
         x = -x;
      end
      z = r * 64'sd16777216;
      for (int i = 0; i < STAGES && i < 24; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_TURNS[i] * 90;
         end else begin
            x += dx; y -= dy; z += ATAN_TURNS[i] * 90;
         end
      end
      ox = floor_shift(x + (64'sd1 <<< 17), 18);
      oy = floor_shift(y + (64'sd1 <<< 17), 18);
   endfunction

   function automatic polar_sum_type add_polar(input logic signed [15:0] m1,
      input logic signed [16:0] a1, input logic signed [15:0] m2,
      input logic signed [16:0] a2);
      longint x1, y1, x2, y2, x, y, z, dx, dy, mag, ang;
      bit flipped;
      polar_sum_type res;
      z = 0;
      flipped = 0;
      polar_to_xy(longint'(m1), longint'(a1), x1, y1);
      polar_to_xy(longint'(m2), longint'(a2), x2, y2);
      x = x1 + x2;
      y = y1 + y2;
      if (x == 0 && y == 0) return '0;
      if (x < 0) begin
         x = -x; y = -y; flipped = 1;
      end
      for (int i = 0; i < STAGES && i < 24; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (y < 0) begin
            x -= dx; y += dy; z -= ATAN_TURNS[i] * 90;
         end else begin
            x += dx; y -= dy; z += ATAN_TURNS[i] * 90;
         end
      end
      mag = floor_shift(x * longint'(pva_pkg::KINV) + (64'sd1 <<< 41), 42);
      if (mag < 0) mag = 0;
      if (mag > longint'(pva_pkg::MAG_LIMIT)) mag = longint'(pva_pkg::MAG_LIMIT);
      ang = floor_shift(z + (64'sd1 <<< 23), 24);
      if (flipped) begin
         if (ang > 0) ang -= pva_pkg::HALF_TURN;
         else ang += pva_pkg::HALF_TURN;
      end
      res.magnitude = mag[16:0];
      res.angle = ang[14:0];
      return res;
   endfunction

   class sum_scoreboard;
      polar_sum_type pending[$];
      int words_in = 0;
      int words_out = 0;

      function void note_request(input logic signed [15:0] m1,
         input logic signed [16:0] a1, input logic signed [15:0] m2,
         input logic signed [16:0] a2);
         pending.push_back(add_polar(m1, a1, m2, a2));
         words_in++;
      endfunction

      task check_result(input logic [16:0] mag, input logic signed [14:0] ang);
         polar_sum_type exp_sum;
         words_out++;
         if (pending.size() == 0) begin
            report_mismatch("result word with nothing expected");
         end else begin
            exp_sum = pending.pop_front();
            if (mag !== exp_sum.magnitude)
               report_mismatch($sformatf("sum_magnitude %0d, expected %0d",
                                         mag, exp_sum.magnitude));
            if (ang !== exp_sum.angle)
               report_mismatch($sformatf("sum_angle %0d, expected %0d",
                                         ang, exp_sum.angle));
         end
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [15:0] req_first_magnitude = '0;
   logic signed [16:0] req_first_angle = '0;
   logic signed [15:0] req_second_magnitude = '0;
   logic signed [16:0] req_second_angle = '0;
   logic rsp_valid;
   logic [16:0] rsp_sum_magnitude;
   logic signed [14:0] rsp_sum_angle;

   sum_scoreboard sums = new();
   int idle_cycles = 0;

   always #1 clock = ~clock;

   polar_vector_adder_unit #(.CORDIC_STAGES(STAGES)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_first_magnitude(req_first_magnitude), .req_first_angle(req_first_angle),
      .req_second_magnitude(req_second_magnitude),
      .req_second_angle(req_second_angle),
      .rsp_valid(rsp_valid), .rsp_sum_magnitude(rsp_sum_magnitude),
      .rsp_sum_angle(rsp_sum_angle));

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sums.note_request(req_first_magnitude, req_first_angle,
                              req_second_magnitude, req_second_angle);
         end
         if (rsp_valid) sums.check_result(rsp_sum_magnitude, rsp_sum_angle);
         if ((start && !busy) || rsp_valid || (sums.pending.size() == 0 && !start))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("Verification failed");
            $finish;
         end
      end
   end

   // one word, start held until taken; at random an idle burst afterwards when allowed
   task automatic send_word(input logic signed [15:0] m1, input logic signed [16:0] a1,
                            input logic signed [15:0] m2, input logic signed [16:0] a2,
                            input bit allow_gap);
      int gap;
      req_first_magnitude <= m1;
      req_first_angle <= a1;
      req_second_magnitude <= m2;
      req_second_angle <= a2;
      start <= 1;
      do @(posedge clock); while (busy);
      gap = (allow_gap && $urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
      @(negedge clock);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain;
      start <= 0;
      while (sums.pending.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [16:0] rand_angle(input int mode);
      int pick;
      int a;
      case (mode)
         0: a = $urandom_range(0, 92160) - 46080;
         1: begin
            pick = $urandom_range(0, 8);
            a = (pick - 4) * 5760 + int'($urandom_range(0, 4)) - 2;
            if (a > 46080) a = 46080;
            if (a < -46080) a = -46080;
         end
         default: a = $urandom_range(0, 131071) - 65536;
      endcase
      return a[16:0];
   endfunction

   initial begin
      logic signed [15:0] m;
      logic signed [16:0] a;
      int mode;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, wraps, cancellation, opposite and zero sums
      send_word(16'sd0, 17'sd0, 16'sd0, 17'sd0, 0);
      send_word(16'sh7fff, 17'sd0, 16'sh7fff, 17'sd0, 0);
      send_word(16'sh8000, 17'sd0, 16'sh8000, 17'sd0, 0);
      send_word(16'sh7fff, 17'sd46080, 16'sh7fff, -17'sd46080, 0);
      send_word(16'sd1000, 17'sd5760, 16'sd1000, 17'sd5761, 0);
      send_word(16'sd1000, -17'sd5760, 16'sd1000, -17'sd5761, 0);
      send_word(16'sd1000, 17'sd11520, 16'sd0, 17'sd0, 0);
      send_word(16'sd1000, -17'sd11520, 16'sd0, 17'sd0, 0);
      send_word(16'sd1000, 17'sd11519, 16'sd1, 17'sd0, 0);
      send_word(16'sd5000, 17'sd0, -16'sd5000, 17'sd0, 0);
      send_word(16'sd5000, 17'sd2000, 16'sd5000, 17'sd13520, 0);
      send_word(-16'sd700, 17'sd3000, 16'sd300, 17'sd23040, 0);
      send_word(16'sd1, 17'sd23040, 16'sd1, -17'sd23040, 0);
      send_word(-16'sd1, 17'sd1, 16'sd0, -17'sd1, 0);
      send_word(16'sh7fff, 17'sd11520, 16'sh8000, 17'sd0, 0);
      send_word(16'sd12345, 17'sd34560, 16'sd0, -17'sd34560, 0);
      send_word(16'sd100, 17'sh0ffff, 16'sd100, 17'sh10000, 0);
      send_word(16'sd0, 17'sd17280, 16'sd2048, -17'sd17280, 0);
      drain();

      for (int n = 0; n < 1750; n++) begin
         mode = $urandom_range(0, 9);
         if (mode < 2) m = 16'($urandom_range(0, 65535));
         else if (mode < 4) m = 16'($urandom_range(0, 64)) - 16'sd32;
         else m = 16'($urandom_range(0, 4095));
         a = rand_angle(mode % 3);
         if (n % 5 == 0)
            send_word(m, a, -m, a, n < 1400);
         else
            send_word(m, a, 16'($urandom_range(0, 65535)), rand_angle(mode % 3),
                      n < 1400);
         if (n == 700) drain();
      end
      drain();
      repeat (LATENCY + 10) @(negedge clock);

      $display("%0d vector pairs sent, %0d sums checked: wraps, extremes, cancellation",
               sums.words_in, sums.words_out);
      if (error_count == 0 && sums.pending.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire
